>>> rtl/u2l_pkg.sv
// u2l_pkg: shared codes, constants and helper functions for the UTF-8 to Latin-1 decoder
// no dependencies; used by u2l_core and the testbench
`default_nettype none

package u2l_pkg;

  // result kinds
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_VALID   = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  // lead byte classes of an open sequence
  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_C2    = 2'd1;
  localparam logic [1:0] CLASS_C3    = 2'd2;

  // byte ranges and mapping constants
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_MIN    = 8'hC0;
  localparam logic [7:0] LEAD_MAX    = 8'hFD;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] LEAD_C2     = 8'd194;
  localparam logic [7:0] LEAD_C3     = 8'd195;
  localparam logic [7:0] C3_OFFSET   = 8'd64;
  localparam logic [7:0] CHAR_UNMAP  = 8'd63;

  // continuation bytes announced by a lead byte, old six-byte form
  function automatic logic [2:0] cont_count(input logic [7:0] lead);
    logic [2:0] n;
    begin
      if (!lead[5]) begin
        n = 3'd1;
      end else if (!lead[4]) begin
        n = 3'd2;
      end else if (!lead[3]) begin
        n = 3'd3;
      end else if (!lead[2]) begin
        n = 3'd4;
      end else begin
        n = 3'd5;
      end
      return n;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/u2l_if.sv
// u2l_byte_if and u2l_result_if: valid/ready channels of the decoder
// no dependencies
`default_nettype none

// one string byte per item
interface u2l_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// one decoded character or string verdict per item
interface u2l_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] result_kind;
  logic       last;

  modport source (output valid, output out_char, output result_kind, output last,
                  input ready);
  modport sink   (input valid, input out_char, input result_kind, input last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/utf8_to_latin1_decoder.sv
// utf8_to_latin1_decoder: top level of the UTF-8 to Latin-1 decoder
// depends on u2l_pkg.sv, u2l_if.sv, u2l_in_reg.sv and u2l_core.sv
//
//  channel    dir   handshake     payload
//  in_ch      in    valid/ready   in_byte[7:0], end_of_string
//  out_ch     out   valid/ready   out_char[7:0], result_kind[1:0], last
//  cfg        in    cfg_write     cfg_data (validate_only)
//
// one byte is accepted every cycle while out_ch does not stall; each byte passes
// through the input register, then through the decode step into the result
// register
// rst is synchronous and clears the mode register, the string state and both valid bits
// when out_ch stalls, the result register holds and in_ch.ready drops once the
// input register is also full
`default_nettype none

module utf8_to_latin1_decoder (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_write,
  input  wire          cfg_data,
  u2l_byte_if.sink     in_ch,
  u2l_result_if.source out_ch
);

  // byte channel between the input register and the decode stage
  u2l_byte_if mid ();

  u2l_in_reg u_in_reg (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (mid)
  );

  u2l_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (mid),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/u2l_in_reg.sv
// u2l_in_reg: input register stage for string bytes
// depends on u2l_if.sv
`default_nettype none

module u2l_in_reg (
  input  wire          clk,
  input  wire          rst,
  u2l_byte_if.sink     in_ch,
  u2l_byte_if.source   out_ch
);

  logic       valid;
  logic [7:0] in_byte;
  logic       end_of_string;

  // take a new item whenever the stage is empty or drains this cycle
  assign in_ch.ready = !valid || out_ch.ready;

  // control bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte       <= in_ch.in_byte;
      end_of_string <= in_ch.end_of_string;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.in_byte       = in_byte;
  assign out_ch.end_of_string = end_of_string;

endmodule

`default_nettype wire

>>> rtl/u2l_core.sv
// u2l_core: sequence state, one-pass decode step and result register
// depends on u2l_pkg.sv and u2l_if.sv
`default_nettype none

module u2l_core (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_write,
  input  wire          cfg_data,
  u2l_byte_if.sink     in_ch,
  u2l_result_if.source out_ch
);

  // mode register
  logic validate_only;

  // string state
  logic [2:0] bytes_remaining;
  logic [7:0] pending_char;
  logic [1:0] lead_class;
  logic       error_seen;
  logic [2:0] bytes_remaining_next;
  logic [7:0] pending_char_next;
  logic [1:0] lead_class_next;
  logic       error_seen_next;

  // result register
  logic       out_valid;
  logic [7:0] out_char;
  logic [1:0] result_kind;
  logic       last;

  // step results
  logic       emit;
  logic [7:0] emit_char;
  logic [1:0] emit_kind;
  logic       emit_last;
  logic       bad;
  logic       done;
  logic [7:0] ch;
  logic [7:0] b;
  logic       eos;
  logic       advance;

  assign b   = in_ch.in_byte;
  assign eos = in_ch.end_of_string;

  // a byte moves on when the result register is free or is being taken
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign advance     = in_ch.valid && in_ch.ready;

  // decode step for the byte in the input register
  always_comb begin
    bytes_remaining_next = bytes_remaining;
    pending_char_next    = pending_char;
    lead_class_next      = lead_class;
    error_seen_next      = error_seen;
    emit      = 1'b0;
    emit_char = 8'd0;
    emit_kind = u2l_pkg::KIND_CHAR;
    emit_last = 1'b0;
    bad       = 1'b0;
    done      = 1'b0;
    ch        = 8'd0;

    if (error_seen) begin
      // drop bytes until the end flag
      if (eos) begin
        bytes_remaining_next = 3'd0;
        pending_char_next    = 8'd0;
        lead_class_next      = u2l_pkg::CLASS_OTHER;
        error_seen_next      = 1'b0;
        if (validate_only) begin
          emit      = 1'b1;
          emit_kind = u2l_pkg::KIND_INVALID;
          emit_last = 1'b1;
        end
      end
    end else begin
      if (bytes_remaining == 3'd0) begin
        // lead position
        if (b < u2l_pkg::ASCII_LIMIT) begin
          ch   = b;
          done = 1'b1;
        end else if (b >= u2l_pkg::LEAD_MIN && b <= u2l_pkg::LEAD_MAX) begin
          bytes_remaining_next = u2l_pkg::cont_count(b);
          if (b == u2l_pkg::LEAD_C2) begin
            lead_class_next   = u2l_pkg::CLASS_C2;
            pending_char_next = 8'd0;
          end else if (b == u2l_pkg::LEAD_C3) begin
            lead_class_next   = u2l_pkg::CLASS_C3;
            pending_char_next = u2l_pkg::C3_OFFSET;
          end else begin
            lead_class_next   = u2l_pkg::CLASS_OTHER;
            pending_char_next = u2l_pkg::CHAR_UNMAP;
          end
        end else begin
          bad = 1'b1;
        end
      end else begin
        // continuation position
        if (b >= u2l_pkg::CONT_MIN && b <= u2l_pkg::CONT_MAX) begin
          if (lead_class != u2l_pkg::CLASS_OTHER) begin
            pending_char_next = pending_char + b;
          end
          bytes_remaining_next = bytes_remaining - 3'd1;
          if (bytes_remaining_next == 3'd0) begin
            ch   = pending_char_next;
            done = 1'b1;
          end
        end else begin
          bad = 1'b1;
        end
      end

      // a sequence cut short by the end flag
      if (eos && !done) begin
        bad = 1'b1;
      end

      if (bad) begin
        bytes_remaining_next = 3'd0;
        pending_char_next    = 8'd0;
        lead_class_next      = u2l_pkg::CLASS_OTHER;
        error_seen_next      = !eos;
        if (eos || !validate_only) begin
          emit      = 1'b1;
          emit_kind = u2l_pkg::KIND_INVALID;
          emit_last = 1'b1;
        end
      end else begin
        if (done) begin
          pending_char_next = 8'd0;
          lead_class_next   = u2l_pkg::CLASS_OTHER;
        end
        if (eos) begin
          bytes_remaining_next = 3'd0;
          pending_char_next    = 8'd0;
          lead_class_next      = u2l_pkg::CLASS_OTHER;
          error_seen_next      = 1'b0;
        end
        if (validate_only) begin
          if (eos) begin
            emit      = 1'b1;
            emit_kind = u2l_pkg::KIND_VALID;
            emit_last = 1'b1;
          end
        end else if (done) begin
          emit      = 1'b1;
          emit_char = ch;
          emit_kind = u2l_pkg::KIND_CHAR;
          emit_last = eos;
        end
      end
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      validate_only <= 1'b0;
    end else if (cfg_write) begin
      validate_only <= cfg_data;
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 3'd0;
      pending_char    <= 8'd0;
      lead_class      <= u2l_pkg::CLASS_OTHER;
      error_seen      <= 1'b0;
    end else if (advance) begin
      bytes_remaining <= bytes_remaining_next;
      pending_char    <= pending_char_next;
      lead_class      <= lead_class_next;
      error_seen      <= error_seen_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= advance && emit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_char    <= emit_char;
      result_kind <= emit_kind;
      last        <= emit_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_char    = out_char;
  assign out_ch.result_kind = result_kind;
  assign out_ch.last        = last;

  // an error leaves no open sequence behind
  assert property (@(posedge clk) disable iff (rst)
    error_seen |-> (bytes_remaining == 3'd0 && lead_class == u2l_pkg::CLASS_OTHER))
    else $error("error state with open sequence");

  // mappable leads always announce exactly one continuation byte
  assert property (@(posedge clk) disable iff (rst)
    lead_class != u2l_pkg::CLASS_OTHER |-> bytes_remaining == 3'd1)
    else $error("mappable lead with wrong remaining count");

  // verdicts carry a zero character and close the string
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != u2l_pkg::KIND_CHAR |-> out_char == 8'd0 && last)
    else $error("verdict with character or without last");

  // the end flag returns the string state to zero
  assert property (@(posedge clk) disable iff (rst)
    advance && eos |=> bytes_remaining == 3'd0 && !error_seen && pending_char == 8'd0)
    else $error("string state not cleared at end flag");

  // a result is only loaded from an accepted byte
  assert property (@(posedge clk) disable iff (rst)
    !$past(out_valid) && !$past(advance) |-> !out_valid)
    else $error("result appeared without a byte");

endmodule

`default_nettype wire

>>> verif/utf8_to_latin1_decoder_test.sv
`timescale 1ns / 100ps
// utf8_to_latin1_decoder_test: self-checking testbench for the UTF-8 to Latin-1 decoder
// needs rtl/u2l_pkg.sv, rtl/u2l_if.sv and the decoder rtl; random stalls on both channels
// a built-in decode model predicts every result, and the monitor checks each field

module utf8_to_latin1_decoder_test;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] kind;
    logic       last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } string_byte_t;

  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES = 80;
  localparam int CHUNK_BYTES = 210;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic cfg_data;

  u2l_byte_if in_ch ();
  u2l_result_if out_ch ();

  utf8_to_latin1_decoder i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // stimulus and prediction state
  string_byte_t byte_queue[$];
  decoded_t expected_results[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned stall_left = 0;

  // decode model state
  logic       validate_mode = 1'b0;
  logic [2:0] cont_left = '0;
  logic [7:0] char_acc = '0;
  logic [1:0] lead_kind = u2l_pkg::CLASS_OTHER;
  logic       str_bad = 1'b0;

  always #5 clk = ~clk;

  // continuation bytes that follow a lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] lead);
    logic [2:0] n;
    casez (lead)
      8'b110?????: n = 3'd1;
      8'b1110????: n = 3'd2;
      8'b11110???: n = 3'd3;
      8'b111110??: n = 3'd4;
      default:     n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic void clear_string();
    cont_left = '0;
    char_acc = '0;
    lead_kind = u2l_pkg::CLASS_OTHER;
    str_bad = 1'b0;
  endfunction

  // advance the decode model by one byte; returns 1 when the byte yields a result
  function automatic bit decode_step(input logic [7:0] b, input logic eos, output decoded_t r);
    logic bad;
    logic done;
    logic [7:0] ch;
    bad = 1'b0;
    done = 1'b0;
    ch = '0;
    r = '{out_char: 8'd0, kind: u2l_pkg::KIND_CHAR, last: 1'b0};

    // after an error only the end of the string matters
    if (str_bad) begin
      if (eos) begin
        clear_string();
        if (validate_mode) begin
          r.kind = u2l_pkg::KIND_INVALID;
          r.last = 1'b1;
          return 1'b1;
        end
      end
      return 1'b0;
    end

    if (cont_left == 3'd0) begin
      if (b < u2l_pkg::ASCII_LIMIT) begin
        ch = b;
        done = 1'b1;
      end else if (b >= u2l_pkg::LEAD_MIN && b <= u2l_pkg::LEAD_MAX) begin
        cont_left = lead_length(b);
        if (b == u2l_pkg::LEAD_C2) begin
          lead_kind = u2l_pkg::CLASS_C2;
          char_acc = 8'd0;
        end else if (b == u2l_pkg::LEAD_C3) begin
          lead_kind = u2l_pkg::CLASS_C3;
          char_acc = u2l_pkg::C3_OFFSET;
        end else begin
          lead_kind = u2l_pkg::CLASS_OTHER;
          char_acc = u2l_pkg::CHAR_UNMAP;
        end
      end else begin
        bad = 1'b1;
      end
    end else begin
      if (b >= u2l_pkg::CONT_MIN && b <= u2l_pkg::CONT_MAX) begin
        if (lead_kind != u2l_pkg::CLASS_OTHER) char_acc = char_acc + b;
        cont_left = cont_left - 3'd1;
        if (cont_left == 3'd0) begin
          ch = char_acc;
          done = 1'b1;
        end
      end else begin
        bad = 1'b1;
      end
    end

    // string ended inside a sequence
    if (!bad && eos && !done) bad = 1'b1;

    if (bad) begin
      r.kind = u2l_pkg::KIND_INVALID;
      r.last = 1'b1;
      if (eos) begin
        clear_string();
        return 1'b1;
      end
      clear_string();
      str_bad = 1'b1;
      return !validate_mode;
    end

    if (done) begin
      char_acc = '0;
      lead_kind = u2l_pkg::CLASS_OTHER;
    end
    if (eos) clear_string();

    if (validate_mode) begin
      if (eos) begin
        r.kind = u2l_pkg::KIND_VALID;
        r.last = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (done) begin
      r.out_char = ch;
      r.last = eos;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // byte driver: predicts each accepted item, then offers the next one
  always @(posedge clk) begin
    string_byte_t item;
    decoded_t res;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= '0;
      in_ch.end_of_string <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        bytes_accepted++;
        if (decode_step(in_ch.in_byte, in_ch.end_of_string, res))
          expected_results.push_back(res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = byte_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= item.data;
          in_ch.end_of_string <= item.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      stall_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    decoded_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item char %02h kind %0d last %0b",
                                  out_ch.out_char, out_ch.result_kind, out_ch.last));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.out_char !== want.out_char)
          report_mismatch($sformatf("out_char %02h, expected %02h",
                                    out_ch.out_char, want.out_char));
        if (out_ch.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d",
                                    out_ch.result_kind, want.kind));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, want.last));
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eos);
    byte_queue.push_back('{data: b, eos: eos});
    bytes_queued++;
  endtask

  // sender pause: all items accepted and every result seen, then the pipeline settles
  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_accepted != bytes_queued || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= mode;
    validate_mode <= mode;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one string, mostly well formed, sometimes broken
  task automatic push_random_string();
    logic [7:0] s[$];
    int n_chars;
    int n_cont;
    int pick;
    n_chars = $urandom_range(1, 8);
    for (int c = 0; c < n_chars; c++) begin
      pick = $urandom_range(0, 9);
      n_cont = 0;
      case (pick)
        0, 1, 2, 3: s.push_back(8'($urandom_range(0, 127)));
        4: begin
          s.push_back(u2l_pkg::LEAD_C2);
          n_cont = 1;
        end
        5: begin
          s.push_back(u2l_pkg::LEAD_C3);
          n_cont = 1;
        end
        6: begin
          s.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          n_cont = 1;
        end
        7: begin
          s.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          n_cont = 2;
        end
        8: begin
          case ($urandom_range(0, 2))
            0: begin
              s.push_back(8'($urandom_range(8'hF0, 8'hF7)));
              n_cont = 3;
            end
            1: begin
              s.push_back(8'($urandom_range(8'hF8, 8'hFB)));
              n_cont = 4;
            end
            default: begin
              s.push_back(8'($urandom_range(8'hFC, 8'hFD)));
              n_cont = 5;
            end
          endcase
        end
        default: s.push_back(8'($urandom_range(0, 255)));
      endcase
      for (int k = 0; k < n_cont; k++) s.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end
    // corrupt a few strings: stray byte or early end
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1)) s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
      else s = s[0:$urandom_range(0, s.size() - 1)];
    end
    foreach (s[i]) push_byte(s[i], i == s.size() - 1);
  endtask

  // watchdog
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // convert mode: zero byte, ascii, both mapped leads, unmappable and longest forms
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(u2l_pkg::LEAD_C2, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(u2l_pkg::LEAD_C3, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b1);
    push_byte(8'hFD, 1'b0);
    for (int k = 0; k < 5; k++) push_byte(8'h80, k == 4);
    // bad lead mid-string, later bytes dropped until the end flag
    push_byte(8'h41, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hFF, 1'b1);
    // sequence cut short, bad byte with the end flag, bad continuation
    push_byte(u2l_pkg::LEAD_C3, 1'b1);
    push_byte(8'hFE, 1'b1);
    push_byte(u2l_pkg::LEAD_C2, 1'b0);
    push_byte(8'h41, 1'b1);
    wait_idle();

    // validate mode: one good and one bad string
    write_mode(1'b1);
    push_byte(8'hC0, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h41, 1'b1);
    // error in validate mode, string closed in convert mode: no item expected
    push_byte(8'hFF, 1'b0);
    wait_idle();
    write_mode(1'b0);
    push_byte(8'h41, 1'b1);
    // open sequence in convert mode, closed in validate mode
    push_byte(u2l_pkg::LEAD_C2, 1'b0);
    wait_idle();
    write_mode(1'b1);
    push_byte(8'hA9, 1'b1);
    wait_idle();

    // random strings: six chunks, alternating mode, three idle patterns
    for (int chunk = 0; chunk < 6; chunk++) begin
      int unsigned chunk_start;
      write_mode(chunk[0]);
      case (chunk / 2)
        0: begin
          send_idle_pct <= 23;
          recv_idle_pct <= 53;
        end
        1: begin
          send_idle_pct <= 53;
          recv_idle_pct <= 23;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      chunk_start = bytes_queued;
      while (bytes_queued - chunk_start < CHUNK_BYTES) push_random_string();
      // long receiver hold-off while the sender keeps offering items
      if (chunk == 4) hold_requests <= hold_requests + 1;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
